@@ rtl/lcc_pkg.sv @@
// Shared constants and types for the card-number Luhn checker.
`timescale 1ns / 1ps
package lcc_pkg;

  localparam int NUM_BITS   = 64;
  localparam int NUM_DIGITS = 20;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int CNT_W      = 6;

  localparam logic [1:0] KIND_INVALID    = 2'd0;
  localparam logic [1:0] KIND_VISA       = 2'd1;
  localparam logic [1:0] KIND_AMEX       = 2'd2;
  localparam logic [1:0] KIND_MASTERCARD = 2'd3;

  // Control word broadcast to every digit cell.
  typedef struct packed {
    logic clear;
    logic dabble;
    logic drain;
  } cell_ctl_t;

  // Verdict of the Luhn accumulator.
  typedef struct packed {
    logic [1:0]         kind;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } verdict_t;

endpackage

@@ rtl/luhn_card_classifier.sv @@
// Top level: Luhn mod-10 checker and card brand classifier.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid / in_stall carries one 64-bit card number per beat.
//   Result channel out_valid / out_stall carries card kind, checksum flag and
//   digit count, one result beat per input beat, in order.
// Operation:
//   A chain of twenty BCD digit cells converts the number by shift-and-add-3,
//   one binary bit per cycle. The chain then drains toward the low end, one
//   digit per cycle, into the Luhn accumulator that sums, counts digits and
//   keeps the leading two digits.
// Sequencing:
//   A number is taken only in idle; it passes through conversion, drain and a
//   done state before the verdict enters the result register, and the next
//   number can be taken only once the block is back in idle.
// Reset:
//   rst_n low (synchronous) returns to idle and empties the result register.
// Stall:
//   A waiting result holds in the output register while the next number is
//   taken and converted; a finished verdict holds until the register frees.
module luhn_card_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_card_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_card_kind,
  output logic        out_checksum_ok,
  output logic [4:0]  out_digit_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int NB = lcc_pkg::NUM_BITS;
  localparam int ND = lcc_pkg::NUM_DIGITS;
  localparam int DW = lcc_pkg::DIGIT_W;

  logic [1:0]                state_r, state_nxt;
  logic [lcc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NB-1:0]             bin_r, bin_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                kind_r, kind_nxt;
  logic                      ok_r, ok_nxt;
  logic [4:0]                count_r, count_nxt;

  logic                      take_in;
  logic                      out_free;
  lcc_pkg::cell_ctl_t        ctl;
  lcc_pkg::verdict_t         verdict;
  logic [ND-1:0]             carry;
  logic [DW-1:0]             digits [ND];

  assign in_stall = (state_r != ST_IDLE);
  assign take_in  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Clear cells on a new number, dabble while converting, drain while scanning.
  assign ctl.clear  = take_in;
  assign ctl.dabble = (state_r == ST_CONV);
  assign ctl.drain  = (state_r == ST_DRAIN);

  genvar k;
  generate
    for (k = 0; k < ND; k++) begin : g_cell
      logic          bit_in_w;
      logic [DW-1:0] up_w;
      if (k == 0) begin : g_low
        assign bit_in_w = bin_r[NB-1];
      end else begin : g_mid
        assign bit_in_w = carry[k-1];
      end
      if (k == ND - 1) begin : g_top
        assign up_w = '0;
      end else begin : g_below
        assign up_w = digits[k+1];
      end
      lcc_digit_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (bit_in_w),
        .bit_out  (carry[k]),
        .up_digit (up_w),
        .digit    (digits[k])
      );
    end
  endgenerate

  lcc_luhn_acc u_acc (
    .clk     (clk),
    .clear   (take_in),
    .en      (state_r == ST_DRAIN),
    .idx     (cnt_r[lcc_pkg::COUNT_W-1:0]),
    .digit   (digits[0]),
    .verdict (verdict)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    bin_nxt       = bin_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    ok_nxt        = ok_r;
    count_nxt     = count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (take_in) begin
          bin_nxt   = in_card_number;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // Advance one binary bit into the low cell each cycle.
        bin_nxt = {bin_r[NB-2:0], 1'b0};
        if (cnt_r == lcc_pkg::CNT_W'(NB - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (cnt_r == lcc_pkg::CNT_W'(ND - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // Hold the verdict until the result register frees.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = verdict.kind;
          ok_nxt        = verdict.ok;
          count_nxt     = verdict.count;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r   <= bin_nxt;
    kind_r  <= kind_nxt;
    ok_r    <= ok_nxt;
    count_r <= count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_card_kind   = kind_r;
  assign out_checksum_ok = ok_r;
  assign out_digit_count = count_r;

`ifndef SYNTHESIS
  a_kind_needs_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_card_kind != lcc_pkg::KIND_INVALID |-> out_checksum_ok)
    else $error("brand reported with failed checksum");

  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count <= 5'd20)
    else $error("digit count above twenty");

  a_visa_len : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_card_kind == lcc_pkg::KIND_VISA |->
      (out_digit_count == 5'd13 || out_digit_count == 5'd16))
    else $error("visa with wrong length");

  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    take_in |=> state_r == ST_CONV && cnt_r == '0)
    else $error("accepted beat did not start conversion");

  a_conv_to_drain : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV && cnt_r == lcc_pkg::CNT_W'(NB - 1) |=> state_r == ST_DRAIN)
    else $error("conversion did not hand over to drain");
`endif

endmodule

@@ rtl/lcc_digit_cell.sv @@
// One BCD digit cell of the binary-to-decimal shift chain.
`timescale 1ns / 1ps
module lcc_digit_cell (
  input  logic                        clk,
  input  lcc_pkg::cell_ctl_t          ctl,
  input  logic                        bit_in,
  output logic                        bit_out,
  input  logic [lcc_pkg::DIGIT_W-1:0] up_digit,
  output logic [lcc_pkg::DIGIT_W-1:0] digit
);

  logic [lcc_pkg::DIGIT_W-1:0] digit_r;
  logic [lcc_pkg::DIGIT_W-1:0] digit_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] adj;

  // Add three when five or more so the shift carries into the next decade.
  assign adj     = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out = adj[3];
  assign digit   = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clear) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctl.drain) begin
      digit_nxt = up_digit;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

@@ rtl/lcc_luhn_acc.sv @@
// Luhn sum, digit count, prefix capture and brand decision over drained digits.
`timescale 1ns / 1ps
module lcc_luhn_acc (
  input  logic                        clk,
  input  logic                        clear,
  input  logic                        en,
  input  logic [lcc_pkg::COUNT_W-1:0] idx,
  input  logic [lcc_pkg::DIGIT_W-1:0] digit,
  output lcc_pkg::verdict_t           verdict
);

  logic [3:0]                  sum_r, sum_nxt;
  logic [lcc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [3:0]                  lead_r, lead_nxt;
  logic [3:0]                  second_r, second_nxt;
  logic [3:0]                  prev_r, prev_nxt;
  logic [4:0]                  term;
  logic [4:0]                  total;
  logic                        ok;

  // Even positions from the right (odd idx) are doubled with digit folding.
  always_comb begin
    if (idx[0]) begin
      term = (digit < 4'd5) ? {digit, 1'b0} : ({digit, 1'b0} - 5'd9);
    end else begin
      term = {1'b0, digit};
    end
    total = {1'b0, sum_r} + term;
    if (total >= 5'd10) begin
      total = total - 5'd10;
    end
  end

  always_comb begin
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    prev_nxt   = prev_r;
    if (clear) begin
      sum_nxt    = '0;
      count_nxt  = '0;
      lead_nxt   = '0;
      second_nxt = '0;
      prev_nxt   = '0;
    end else if (en) begin
      sum_nxt  = total[3:0];
      prev_nxt = digit;
      if (digit != 4'd0) begin
        count_nxt  = idx + 5'd1;
        lead_nxt   = digit;
        second_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    count_r  <= count_nxt;
    lead_r   <= lead_nxt;
    second_r <= second_nxt;
    prev_r   <= prev_nxt;
  end

  assign ok = (sum_r == 4'd0);

  always_comb begin
    verdict.ok    = ok;
    verdict.count = count_r;
    verdict.kind  = lcc_pkg::KIND_INVALID;
    if (ok) begin
      if ((count_r == 5'd13 || count_r == 5'd16) && lead_r == 4'd4) begin
        verdict.kind = lcc_pkg::KIND_VISA;
      end else if (count_r == 5'd15 && lead_r == 4'd3 &&
                   (second_r == 4'd4 || second_r == 4'd7)) begin
        verdict.kind = lcc_pkg::KIND_AMEX;
      end else if (count_r == 5'd16 && lead_r == 4'd5 &&
                   (second_r inside {[4'd1:4'd5]})) begin
        verdict.kind = lcc_pkg::KIND_MASTERCARD;
      end
    end
  end

endmodule
